>>> hw/rtl/mbri_pkg.sv
// Shared types, codes and the CRC-16 step for the Modbus read-input slave.
package mbri_pkg;

   // Request item commands
   localparam logic [1:0] CMD_RX_BYTE   = 2'd0;
   localparam logic [1:0] CMD_GAP       = 2'd1;
   localparam logic [1:0] CMD_STORE_WR  = 2'd2;

   localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;

   localparam int REQ_LEN       = 8;
   localparam int COUNT_SAT     = 31;
   localparam int COUNT_W       = 5;   // register count, at most 31; the front end limits it to MAX_READ_REGS
   localparam int INDEX_W       = 5;
   localparam int QUEUE_DEPTH   = 4;

   localparam int DEF_STORE_BYTES   = 32;
   localparam int DEF_MAX_READ_REGS = 13;

   // Job handed from front to back
   typedef struct packed {
      logic               is_reply;   // 1 reply job, 0 store write
      logic [7:0]         addr;       // slave address echoed in the reply
      logic [15:0]        start;      // first register
      logic [COUNT_W-1:0] count;      // registers to read
      logic [INDEX_W-1:0] index;      // store write position
      logic [7:0]         data;       // store write data
   } job_type;

   // One byte through the Modbus CRC-16, LSB first
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/mbri_front.sv
// Front end: collects request bytes, checks the frame and queues jobs.
module mbri_front
   import mbri_pkg::*;
#(
   parameter int STORE_BYTES   = DEF_STORE_BYTES,
   parameter int MAX_READ_REGS = DEF_MAX_READ_REGS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_data_byte,
   input  logic [INDEX_W-1:0] req_store_index,
   input  logic [7:0]         slave_address,
   input  logic               q_full,
   output logic               q_push,
   output job_type            q_job
);

   logic [7:0]  frame_ff [REQ_LEN];
   logic [4:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic        accept;
   logic        frame_ok;
   logic        index_ok;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // Request check at the gap
   assign frame_ok = (count_ff == 5'(REQ_LEN))
                  && (frame_ff[0] == slave_address)
                  && (frame_ff[1] == FUNC_READ_INPUT)
                  && (frame_ff[6] == crc_ff[7:0])
                  && (frame_ff[7] == crc_ff[15:8])
                  && ({frame_ff[4], frame_ff[5]} <= 16'(MAX_READ_REGS));

   assign index_ok = 9'(req_store_index) < 9'(STORE_BYTES);

   // Classify the transfer and build the job
   always_comb begin
      count_in       = count_ff;
      crc_in         = crc_ff;
      q_push         = 1'b0;
      q_job.is_reply = (req_cmd == CMD_GAP);
      q_job.addr     = slave_address;
      q_job.start    = {frame_ff[2], frame_ff[3]};
      q_job.count    = frame_ff[5][COUNT_W-1:0];
      q_job.index    = req_store_index;
      q_job.data     = req_data_byte;
      if (accept) begin
         unique case (req_cmd)
            CMD_RX_BYTE: begin
               if (count_ff < 5'd6) crc_in = crc_step(crc_ff, req_data_byte);
               if (count_ff < 5'(COUNT_SAT)) count_in = count_ff + 5'd1;
            end
            CMD_GAP: begin
               count_in = '0;
               crc_in   = CRC_INIT;
               q_push   = frame_ok;
            end
            CMD_STORE_WR: begin
               q_push = index_ok;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= CRC_INIT;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
   end

   // Frame bytes hold the first REQ_LEN received bytes, address and CRC included
   always_ff @(posedge clock) begin
      if (accept && req_cmd == CMD_RX_BYTE && count_ff < 5'(REQ_LEN)) begin
         frame_ff[count_ff[2:0]] <= req_data_byte;
      end
   end

endmodule

>>> hw/rtl/mbri_queue.sv
// Short job queue between the front end and the reply sequencer.
module mbri_queue
   import mbri_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   job_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   fill_ff, fill_in;
   logic            do_push, do_pop;

   assign full    = (fill_ff == CW'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = slot_ff[rd_ptr_ff];

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) fill_in = fill_ff + CW'(1);
      if (do_pop && !do_push) fill_in = fill_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
   end

endmodule

>>> hw/rtl/mbri_back.sv
// Back end: register store, reply sequencer and result register.
module mbri_back
   import mbri_pkg::*;
#(
   parameter int STORE_BYTES   = DEF_STORE_BYTES,
   parameter int MAX_READ_REGS = DEF_MAX_READ_REGS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  job_type    q_job,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last
);

   localparam int AW   = $clog2(STORE_BYTES);
   localparam int NB_W = $clog2(2 * MAX_READ_REGS + 1);
   localparam int PSW  = 18;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ADDR = 3'd1;
   localparam logic [2:0] S_FUNC = 3'd2;
   localparam logic [2:0] S_BCNT = 3'd3;
   localparam logic [2:0] S_RD   = 3'd4;
   localparam logic [2:0] S_DATA = 3'd5;
   localparam logic [2:0] S_CRCL = 3'd6;
   localparam logic [2:0] S_CRCH = 3'd7;

   logic [7:0]             mem [STORE_BYTES];
   logic [STORE_BYTES-1:0] valid_ff;
   logic [7:0]             rdata_ff;
   logic                   rvalid_ff;

   logic [2:0]      state_ff, state_in;
   logic [PSW-1:0]  pos_ff, pos_in;
   logic [NB_W-1:0] cnt_ff, cnt_in;
   logic [7:0]      addr_ff, addr_in;
   logic [15:0]     crc_ff, crc_in;

   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_byte_ff, out_byte_in;
   logic            out_last_ff, out_last_in;

   logic            out_free;
   logic            emit;
   logic [7:0]      emit_byte;
   logic            mem_wr;
   logic [AW-1:0]   waddr;
   logic [AW-1:0]   raddr;
   logic            rd_in_range;

   assign out_free    = !out_valid_ff || rsp_pop;
   assign rsp_empty   = !out_valid_ff;
   assign rsp_tx_byte = out_byte_ff;
   assign rsp_last    = out_last_ff;

   assign waddr       = AW'(q_job.index);
   assign raddr       = pos_ff[AW-1:0];
   assign rd_in_range = pos_ff < PSW'(STORE_BYTES);

   // Reply sequencer
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      addr_in   = addr_ff;
      crc_in    = crc_ff;
      q_pop     = 1'b0;
      mem_wr    = 1'b0;
      emit      = 1'b0;
      emit_byte = 8'h00;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_job.is_reply) begin
                  pos_in   = {1'b0, q_job.start, 1'b0};
                  cnt_in   = NB_W'({q_job.count, 1'b0});
                  addr_in  = q_job.addr;
                  crc_in   = CRC_INIT;
                  state_in = S_ADDR;
               end else begin
                  mem_wr = 1'b1;
               end
            end
         end
         S_ADDR: begin
            emit_byte = addr_ff;
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_FUNC;
            end
         end
         S_FUNC: begin
            emit_byte = FUNC_READ_INPUT;
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_BCNT;
            end
         end
         S_BCNT: begin
            emit_byte = 8'(cnt_ff);
            if (out_free) begin
               emit     = 1'b1;
               state_in = (cnt_ff == '0) ? S_CRCL : S_RD;
            end
         end
         S_RD: begin
            // read issued from pos_ff, data lands next cycle
            state_in = S_DATA;
         end
         S_DATA: begin
            emit_byte = rvalid_ff ? rdata_ff : 8'h00;
            if (out_free) begin
               emit     = 1'b1;
               pos_in   = pos_ff + PSW'(1);
               cnt_in   = cnt_ff - NB_W'(1);
               state_in = (cnt_ff == NB_W'(1)) ? S_CRCL : S_RD;
            end
         end
         S_CRCL: begin
            emit_byte = crc_ff[7:0];
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_CRCH;
            end
         end
         S_CRCH: begin
            emit_byte = crc_ff[15:8];
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // running CRC over header and data bytes
      if (emit && state_ff != S_CRCL && state_ff != S_CRCH) begin
         crc_in = crc_step(crc_ff, emit_byte);
      end
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (rsp_pop) out_valid_in = 1'b0;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_last_in  = (state_ff == S_CRCH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (mem_wr) valid_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      cnt_ff      <= cnt_in;
      addr_ff     <= addr_in;
      crc_ff      <= crc_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   // Register store, registered read; unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (mem_wr) mem[waddr] <= q_job.data;
      rdata_ff  <= mem[raddr];
      rvalid_ff <= rd_in_range && valid_ff[raddr];
   end

endmodule

>>> hw/rtl/modbus_rtu_read_input_slave_unit.sv
// Top level of the Modbus RTU read-input-registers slave.
// After a frame gap, when the sequencer is idle, the reply job passes the job queue,
//   then the sequencer and the result register before the first reply byte shows.
// Throughput: one request item per cycle while the job queue has room; reply bytes
//   go out one per cycle for the header and CRC while rsp_pop takes them; each store
//   data byte waits for a registered store read, then goes to the result register.
// Reset (synchronous, active high): frame count cleared, queue and sequencer empty,
//   store reads as zero, slave address 1.
module modbus_rtu_read_input_slave_unit
   import mbri_pkg::*;
#(
   parameter int STORE_BYTES   = DEF_STORE_BYTES,
   parameter int MAX_READ_REGS = DEF_MAX_READ_REGS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_data_byte,
   input  logic [INDEX_W-1:0] req_store_index,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [7:0]         rsp_tx_byte,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_data
);

   logic [7:0] slave_address_ff;
   logic       q_full, q_empty, q_push, q_pop;
   job_type    push_job, pop_job;

   // Slave address register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= 8'd1;
      end else if (csr_valid && csr_ready) begin
         slave_address_ff <= csr_data;
      end
   end

   mbri_front #(
      .STORE_BYTES   (STORE_BYTES),
      .MAX_READ_REGS (MAX_READ_REGS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_data_byte   (req_data_byte),
      .req_store_index (req_store_index),
      .slave_address   (slave_address_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_job           (push_job)
   );

   mbri_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   mbri_back #(
      .STORE_BYTES   (STORE_BYTES),
      .MAX_READ_REGS (MAX_READ_REGS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_job       (pop_job),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_last    (rsp_last)
   );

endmodule
